@@ rtl/core/srec_s3_record_checker_macros.svh @@
// Assertion macros for the S3 record checker.
// Included by the top level; depends on nothing else.
`ifndef SREC_S3_RECORD_CHECKER_MACROS_SVH
`define SREC_S3_RECORD_CHECKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define SREC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define SREC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/core/srec_pkg.sv @@
// Shared constants, types and helpers for the S3 record checker.
// No dependencies.
package srec_pkg;

	// Buffer depth default
	localparam int MAX_DATA_BYTES_DEF = 16;

	// Field widths
	localparam int CH_W     = 8;
	localparam int STATUS_W = 3;
	localparam int ADDR_W   = 32;
	localparam int BYTE_W   = 8;
	localparam int POS_W    = 10;
	localparam int SEEN_W   = 9;
	localparam int S_TDATA_W = 8;
	localparam int M_TDATA_W = 48;

	// Saturation limits
	localparam logic [POS_W-1:0]  POS_MAX  = '1;
	localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

	// Count byte overhead: four address bytes plus the checksum
	localparam logic [BYTE_W-1:0] COUNT_MIN = 8'd5;

	// Result status codes
	localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_CHECKSUM  = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_ALIGN     = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_TOO_LONG  = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_MALFORMED = 3'd4;

	// Record lead characters
	localparam logic [CH_W-1:0] CH_S     = 8'h53;
	localparam logic [CH_W-1:0] CH_THREE = 8'h33;

	typedef struct packed {
		logic       ok;
		logic [3:0] nib;
	} hex_t;

	// ASCII hex digit decode, upper and lower case
	function automatic hex_t hex_decode(input logic [CH_W-1:0] c);
		hex_t r;
		r.ok  = 1'b1;
		r.nib = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.nib = c[3:0];
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			r.nib = 4'(c[2:0] + 3'd0) + 4'd9;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

@@ rtl/core/srec_s3_record_checker.sv @@
// S3 record checker top level: character decode, record check and result drain.
// Depends on srec_pkg and srec_s3_record_checker_macros.svh.
`include "srec_s3_record_checker_macros.svh"

// One record character is taken per cycle while the block receives; hex pairs
// are decoded on the fly into count, address and up to MAX_DATA_BYTES buffered
// data bytes. The transaction with tlast set ends the record: a check state then
// checks it (malformed, checksum, alignment, length, in that order) and the
// drain sequencer emits one result per cycle, while the output side accepts,
// through the address incrementer: one per data byte on success with data, or a
// single status result otherwise. No character is taken during the check and
// drain. Result tdata: status [2:0], byte_address [34:3], data_byte [42:35],
// zero fill [47:43]; tuser is has_data, tlast is final_result.
module srec_s3_record_checker #(
	parameter int MAX_DATA_BYTES = srec_pkg::MAX_DATA_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input stream
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [srec_pkg::S_TDATA_W-1:0] s_axis_tdata,  // ch [7:0]
	input  logic                          s_axis_tlast,  // end_of_record
	// result stream
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [srec_pkg::M_TDATA_W-1:0] m_axis_tdata,  // status, byte_address, data_byte
	output logic                          m_axis_tuser,  // has_data
	output logic                          m_axis_tlast   // final_result
);
	import srec_pkg::*;

	localparam int IDX_W = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;
	localparam logic [SEEN_W-1:0] MAX_SEEN = SEEN_W'(MAX_DATA_BYTES);

	// Sequencer codes
	localparam logic [1:0] SQ_RECV  = 2'd0;
	localparam logic [1:0] SQ_CHECK = 2'd1;
	localparam logic [1:0] SQ_EMIT  = 2'd2;

	logic [1:0] state_q;

	// Record state
	logic [POS_W-1:0]  char_position_q;
	logic [3:0]        high_nibble_q;
	logic [BYTE_W-1:0] running_sum_q;
	logic [BYTE_W-1:0] pending_byte_q;
	logic [BYTE_W-1:0] count_byte_q;
	logic [ADDR_W-1:0] record_address_q;
	logic [SEEN_W-1:0] bytes_seen_q;
	logic              malformed_q;
	logic [BYTE_W-1:0] data_store_q [MAX_DATA_BYTES];

	// Drain state
	logic [STATUS_W-1:0] chk_status_q;
	logic [BYTE_W-1:0]   len_q;
	logic [BYTE_W-1:0]   emit_idx_q;
	logic [ADDR_W-1:0]   addr_q;

	// Output register
	logic                m_valid_q;
	logic [STATUS_W-1:0] m_status_q;
	logic [ADDR_W-1:0]   m_addr_q;
	logic [BYTE_W-1:0]   m_data_q;
	logic                m_has_q;
	logic                m_fin_q;

	logic              in_acc;
	logic              out_free;
	hex_t              hex;
	logic              take;
	logic [BYTE_W-1:0] new_byte;
	logic [SEEN_W-1:0] store_off;
	logic              store_wr;
	logic [STATUS_W-1:0] status_c;
	logic              single_res;
	logic              emit_fin;
	logic              emit_go;

	assign s_axis_tready = (state_q == SQ_RECV);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;

	// Character decode
	assign hex       = hex_decode(s_axis_tdata);
	assign take      = in_acc && (char_position_q >= POS_W'(2)) && char_position_q[0];
	assign new_byte  = {high_nibble_q, hex.nib};
	assign store_off = bytes_seen_q - SEEN_W'(5);
	assign store_wr  = take && (bytes_seen_q >= SEEN_W'(5)) && (store_off < MAX_SEEN);

	// Record check, priority order decides the status
	always_comb begin
		priority if (malformed_q || char_position_q < POS_W'(2) || char_position_q[0] ||
		             count_byte_q < COUNT_MIN ||
		             bytes_seen_q != ({1'b0, count_byte_q} + SEEN_W'(1))) begin
			status_c = STAT_MALFORMED;
		end else if (~running_sum_q != pending_byte_q) begin
			status_c = STAT_CHECKSUM;
		end else if (record_address_q[1:0] != 2'b00) begin
			status_c = STAT_ALIGN;
		end else if ({1'b0, count_byte_q - COUNT_MIN} > MAX_SEEN) begin
			status_c = STAT_TOO_LONG;
		end else begin
			status_c = STAT_OK;
		end
	end

	// Drain step decisions
	assign single_res = (chk_status_q != STAT_OK) || (len_q == '0);
	assign emit_fin   = single_res || ((emit_idx_q + BYTE_W'(1)) == len_q);
	assign emit_go    = (state_q == SQ_EMIT) && out_free;

	// Sequencer and record control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= SQ_RECV;
			char_position_q  <= '0;
			high_nibble_q    <= '0;
			running_sum_q    <= '0;
			pending_byte_q   <= '0;
			count_byte_q     <= '0;
			record_address_q <= '0;
			bytes_seen_q     <= '0;
			malformed_q      <= 1'b0;
			chk_status_q     <= STAT_OK;
			len_q            <= '0;
			emit_idx_q       <= '0;
			addr_q           <= '0;
			m_valid_q        <= 1'b0;
		end else begin
			unique case (state_q)
				SQ_RECV: begin
					if (in_acc) begin
						// lead characters, then hex pairs
						if (char_position_q == POS_W'(0)) begin
							if (s_axis_tdata != CH_S) malformed_q <= 1'b1;
						end else if (char_position_q == POS_W'(1)) begin
							if (s_axis_tdata != CH_THREE) malformed_q <= 1'b1;
						end else begin
							if (!hex.ok) malformed_q <= 1'b1;
							if (!char_position_q[0]) high_nibble_q <= hex.nib;
						end
						if (char_position_q != POS_MAX) begin
							char_position_q <= char_position_q + POS_W'(1);
						end else begin
							malformed_q <= 1'b1;
						end
						if (s_axis_tlast) state_q <= SQ_CHECK;
					end
					// completed byte: sum the previous one, route the new one
					if (take) begin
						if (bytes_seen_q != '0) running_sum_q <= running_sum_q + pending_byte_q;
						pending_byte_q <= new_byte;
						if (bytes_seen_q == '0) begin
							count_byte_q <= new_byte;
						end else if (bytes_seen_q <= SEEN_W'(4)) begin
							record_address_q <= {record_address_q[ADDR_W-9:0], new_byte};
						end
						if (bytes_seen_q != SEEN_MAX) bytes_seen_q <= bytes_seen_q + SEEN_W'(1);
					end
				end
				SQ_CHECK: begin
					chk_status_q     <= status_c;
					len_q            <= count_byte_q - COUNT_MIN;
					emit_idx_q       <= '0;
					addr_q           <= record_address_q;
					char_position_q  <= '0;
					high_nibble_q    <= '0;
					running_sum_q    <= '0;
					pending_byte_q   <= '0;
					count_byte_q     <= '0;
					record_address_q <= '0;
					bytes_seen_q     <= '0;
					malformed_q      <= 1'b0;
					state_q          <= SQ_EMIT;
				end
				SQ_EMIT: begin
					if (emit_go) begin
						addr_q     <= addr_q + ADDR_W'(1);
						emit_idx_q <= emit_idx_q + BYTE_W'(1);
						if (emit_fin) state_q <= SQ_RECV;
					end
				end
				default: state_q <= SQ_RECV;
			endcase

			// output valid
			if (emit_go) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Data buffer and result payload
	always_ff @(posedge clk) begin
		if (store_wr) data_store_q[store_off[IDX_W-1:0]] <= new_byte;
		if (emit_go) begin
			m_fin_q <= emit_fin;
			if (single_res) begin
				m_status_q <= chk_status_q;
				m_addr_q   <= '0;
				m_data_q   <= '0;
				m_has_q    <= 1'b0;
			end else begin
				m_status_q <= STAT_OK;
				m_addr_q   <= addr_q;
				m_data_q   <= data_store_q[emit_idx_q[IDX_W-1:0]];
				m_has_q    <= 1'b1;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {5'b0, m_data_q, m_addr_q, m_status_q};
	assign m_axis_tuser  = m_has_q;
	assign m_axis_tlast  = m_fin_q;

	// Checks
	`SREC_ASSERT_NEXT(a_end_stops_input, clk, arst_n,
		in_acc && s_axis_tlast, !s_axis_tready)
	`SREC_ASSERT_IMPL(a_status_is_final, clk, arst_n,
		m_axis_tvalid && !m_axis_tuser, m_axis_tlast)
	`SREC_ASSERT_IMPL(a_drain_in_range, clk, arst_n,
		state_q == SQ_EMIT && !single_res, emit_idx_q < len_q)

endmodule
